FILE: rtl/prrt_pkg.sv
// Package for the pending request resend table.
// Holds field widths, action and result codes, and the request, result and
// table entry types. No dependencies.
package prrt_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned ID_BITS     = 16;
  localparam int unsigned HANDLE_BITS = 32;
  localparam int unsigned COUNT_BITS  = 8;

  localparam logic [1:0] ACT_SEND   = 2'd0;
  localparam logic [1:0] ACT_ACK    = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;
  // Unused action code: dropped with no results.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [2:0] KIND_TRANSMIT    = 3'd0;
  localparam logic [2:0] KIND_RETRANSMIT  = 3'd1;
  localparam logic [2:0] KIND_NO_RESPONSE = 3'd2;
  localparam logic [2:0] KIND_DUPLICATE   = 3'd3;
  localparam logic [2:0] KIND_FULL        = 3'd4;

  localparam logic [COUNT_BITS-1:0] MAX_RESEND_RST = 8'd3;

  typedef struct packed {
    logic [1:0]             action;
    logic [ID_BITS-1:0]     request_id;
    logic [HANDLE_BITS-1:0] payload_handle;
  } req_t;

  typedef struct packed {
    logic [2:0]             result_kind;
    logic [ID_BITS-1:0]     result_id;
    logic [HANDLE_BITS-1:0] result_handle;
    logic                   last;
  } res_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0]  resends;
    logic [ID_BITS-1:0]     id;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

endpackage

FILE: rtl/prrt_ram.sv
// Generic single-clock RAM: one write port, one read port with registered,
// enabled read data. No dependencies.
module prrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/pending_request_resend_table_core.sv
// Pending request resend table: top level with scan sequencer and valid bits.
// Depends on prrt_pkg and prrt_ram (entry id, handle and count storage).
//
//   channel   direction  handshake                     payload
//   in        input      in_valid_i / in_ready_o       in_req_i  (prrt_pkg::req_t)
//   out       output     out_valid_o / out_ready_i     out_res_o (prrt_pkg::res_t)
//   cfg       input      cfg_we_i                      cfg_wdata_i (max_resend)
//
// Every request but an unused action scans all ENTRIES slots through the entry
// RAM read port, one slot a cycle unless a tick scan stalls, pipelined: an accept
// step, the scan, then one or two results for a send. An unused action is
// dropped on acceptance. A tick writes each updated count back behind the scan.
// Reset clears the valid bits and the output valid; no clearing pass.
// A full output register stalls a tick scan and holds a send's result cycles;
// a new request is taken after the scan and any send results, even while one waits.
module pending_request_resend_table_core #(
  parameter int unsigned ENTRIES = prrt_pkg::ENTRIES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  prrt_pkg::req_t                      in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output prrt_pkg::res_t                      out_res_o,
  input  logic                                cfg_we_i,
  input  logic [prrt_pkg::COUNT_BITS-1:0]     cfg_wdata_i
);

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_TX   = 2'd2;
  localparam logic [1:0] S_ERR  = 2'd3;

  logic [1:0]                        state_q, state_d;
  prrt_pkg::req_t                    req_q, req_d;
  logic [CW-1:0]                     rd_cnt_q, rd_cnt_d;
  logic                              ev_vld_q, ev_vld_d;
  logic [AW-1:0]                     ev_idx_q, ev_idx_d;
  logic                              dup_q, dup_d;
  logic                              free_found_q, free_found_d;
  logic [AW-1:0]                     free_idx_q, free_idx_d;
  logic [ENTRIES-1:0]                valid_q, valid_d;
  logic [prrt_pkg::COUNT_BITS-1:0]   max_resend_q;
  logic                              out_valid_q, out_valid_d;
  prrt_pkg::res_t                    out_q, out_d;

  logic                              ram_we;
  logic [AW-1:0]                     ram_waddr;
  prrt_pkg::entry_t                  ram_wdata;
  logic                              ram_re;
  logic [AW-1:0]                     ram_raddr;
  prrt_pkg::entry_t                  ram_rdata;

  logic                              can_load;
  logic                              ev_hit;
  logic                              stall;
  logic                              more_after;
  logic [ENTRIES-1:0]                after_mask;

  prrt_ram #(
    .WIDTH ($bits(prrt_pkg::entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign can_load = !out_valid_q || out_ready_i;
  assign ev_hit   = ev_vld_q && valid_q[ev_idx_q];
  assign stall    = ev_hit && (req_q.action == prrt_pkg::ACT_TICK) && !can_load;

  // Any valid slot beyond the one under evaluation decides the last flag.
  always_comb begin
    for (int j = 0; j < ENTRIES; j++) begin
      after_mask[j] = (j > int'(ev_idx_q));
    end
  end
  assign more_after = |(valid_q & after_mask);

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    rd_cnt_d     = rd_cnt_q;
    ev_vld_d     = ev_vld_q;
    ev_idx_d     = ev_idx_q;
    dup_d        = dup_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    valid_d      = valid_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    ram_we       = 1'b0;
    ram_waddr    = ev_idx_q;
    ram_wdata    = ram_rdata;
    ram_re       = 1'b0;
    ram_raddr    = rd_cnt_q[AW-1:0];
    in_ready_o   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d        = in_req_i;
          rd_cnt_d     = '0;
          ev_vld_d     = 1'b0;
          dup_d        = 1'b0;
          free_found_d = 1'b0;
          // Unused action code: drop the request.
          if (in_req_i.action != prrt_pkg::ACT_UNUSED) begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (!stall) begin
          if (rd_cnt_q != CW'(ENTRIES)) begin
            ram_re   = 1'b1;
            rd_cnt_d = rd_cnt_q + 1'b1;
            ev_vld_d = 1'b1;
            ev_idx_d = rd_cnt_q[AW-1:0];
          end else begin
            ev_vld_d = 1'b0;
            state_d  = (req_q.action == prrt_pkg::ACT_SEND) ? S_TX : S_IDLE;
          end

          if (ev_vld_q) begin
            case (req_q.action)
              prrt_pkg::ACT_SEND: begin
                if (ev_hit && ram_rdata.id == req_q.request_id) begin
                  dup_d = 1'b1;
                end
                if (!valid_q[ev_idx_q] && !free_found_q) begin
                  free_found_d = 1'b1;
                  free_idx_d   = ev_idx_q;
                end
              end
              prrt_pkg::ACT_ACK: begin
                if (ev_hit && ram_rdata.id == req_q.request_id) begin
                  valid_d[ev_idx_q] = 1'b0;
                end
              end
              prrt_pkg::ACT_TICK: begin
                if (ev_hit) begin
                  out_valid_d         = 1'b1;
                  out_d.result_id     = ram_rdata.id;
                  out_d.result_handle = ram_rdata.handle;
                  out_d.last          = !more_after;
                  if (ram_rdata.resends < max_resend_q) begin
                    out_d.result_kind = prrt_pkg::KIND_RETRANSMIT;
                    ram_we            = 1'b1;
                    ram_wdata.resends = ram_rdata.resends + 1'b1;
                  end else begin
                    out_d.result_kind = prrt_pkg::KIND_NO_RESPONSE;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
      end

      S_TX: begin
        if (can_load) begin
          out_valid_d         = 1'b1;
          out_d.result_kind   = prrt_pkg::KIND_TRANSMIT;
          out_d.result_id     = req_q.request_id;
          out_d.result_handle = req_q.payload_handle;
          out_d.last          = !dup_q && free_found_q;
          if (dup_q || !free_found_q) begin
            state_d = S_ERR;
          end else begin
            ram_we            = 1'b1;
            ram_waddr         = free_idx_q;
            ram_wdata.resends = '0;
            ram_wdata.id      = req_q.request_id;
            ram_wdata.handle  = req_q.payload_handle;
            valid_d[free_idx_q] = 1'b1;
            state_d           = S_IDLE;
          end
        end
      end

      S_ERR: begin
        if (can_load) begin
          out_valid_d         = 1'b1;
          out_d.result_kind   = dup_q ? prrt_pkg::KIND_DUPLICATE : prrt_pkg::KIND_FULL;
          out_d.result_id     = req_q.request_id;
          out_d.result_handle = req_q.payload_handle;
          out_d.last          = 1'b1;
          state_d             = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rd_cnt_q     <= '0;
      ev_vld_q     <= 1'b0;
      dup_q        <= 1'b0;
      free_found_q <= 1'b0;
      valid_q      <= '0;
      max_resend_q <= prrt_pkg::MAX_RESEND_RST;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      rd_cnt_q     <= rd_cnt_d;
      ev_vld_q     <= ev_vld_d;
      dup_q        <= dup_d;
      free_found_q <= free_found_d;
      valid_q      <= valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        max_resend_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    ev_idx_q   <= ev_idx_d;
    free_idx_q <= free_idx_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

FILE: rtl/prrt_checker.sv
// Port-level checker for the pending request resend table, with its bind.
// Depends on prrt_pkg and the top level pending_request_resend_table_core.
module prrt_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input prrt_pkg::res_t out_res_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_res_o))
    else $error("stalled result changed");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_res_o.result_kind <= prrt_pkg::KIND_FULL)
    else $error("result kind out of range");

  // An error result always closes its request.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_res_o.result_kind == prrt_pkg::KIND_DUPLICATE ||
                    out_res_o.result_kind == prrt_pkg::KIND_FULL)
    |-> out_res_o.last)
    else $error("error result not marked last");

  // A transmit that is not last is followed at once by its error result.
  a_tx_then_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_res_o.result_kind == prrt_pkg::KIND_TRANSMIT &&
    !out_res_o.last
    |=> out_valid_o && (out_res_o.result_kind == prrt_pkg::KIND_DUPLICATE ||
                        out_res_o.result_kind == prrt_pkg::KIND_FULL))
    else $error("open transmit not followed by error result");

  // No request is taken while a send still owes its error result.
  a_no_accept_open_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.result_kind == prrt_pkg::KIND_TRANSMIT &&
    !out_res_o.last |-> !(in_valid_i && in_ready_o))
    else $error("request taken during open send");

endmodule

bind pending_request_resend_table_core prrt_checker u_prrt_checker (.*);
